// ===== design/cfr_pkg.sv =====
`timescale 1ns / 1ps

package cfr_pkg;

  // fixed field widths
  localparam int IDX_W          = 6;
  localparam int ACT_W          = 2;
  localparam int NUM_FRAMES_DEF = 64;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TOUCH = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_AIM,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // per-frame flags, one RAM word
  typedef struct packed {
    logic occupied;
    logic accessed;
    logic dirty;
    logic swap_backed;
  } frame_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_frame;
    logic             did_evict;
    logic             swap_out;
    logic             status;
  } rsp_t;

  // fresh page in a slot
  function automatic frame_t place_page(input logic sb);
    frame_t f;
    f.occupied    = 1'b1;
    f.accessed    = 1'b0;
    f.dirty       = 1'b0;
    f.swap_backed = sb;
    return f;
  endfunction

endpackage

// ===== design/cfr_ram.sv =====
`timescale 1ns / 1ps

module cfr_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/cfr_step.sv =====
`timescale 1ns / 1ps

// Cyclic frame cursor advance, shared by clear, scan, aim and sweep.
module cfr_step #(
  parameter int NUM_FRAMES = 64
) (
  input  logic [$clog2(NUM_FRAMES)-1:0] operand,
  output logic [$clog2(NUM_FRAMES)-1:0] next,
  output logic                          last
);

  localparam int FRAME_W = $clog2(NUM_FRAMES);

  assign last = (operand == FRAME_W'(NUM_FRAMES - 1));
  assign next = last ? '0 : operand + FRAME_W'(1);

endmodule

// ===== design/cfr_ctrl.sv =====
`timescale 1ns / 1ps

module cfr_ctrl #(
  parameter int NUM_FRAMES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [cfr_pkg::ACT_W-1:0]    action,
  input  logic [cfr_pkg::IDX_W-1:0]    frame_index,
  input  logic                         is_write,
  input  logic                         page_swap_backed,
  output logic                         res_valid,
  input  logic                         res_ready,
  output cfr_pkg::rsp_t                res
);

  import cfr_pkg::*;

  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int CMP_W   = ((FRAME_W > IDX_W) ? FRAME_W : IDX_W) + 1;

  state_t state, state_next;
  logic [FRAME_W-1:0] cur, cur_next;
  logic [FRAME_W-1:0] hand, hand_next;
  logic               hand_valid, hand_valid_next;
  rsp_t               res_r, res_next;

  logic [ACT_W-1:0] act_r, act_next;
  logic [IDX_W-1:0] idx_r, idx_next;
  logic             wr_r, wr_next;
  logic             sb_r, sb_next;

  logic               ram_wr_en;
  logic [FRAME_W-1:0] ram_wr_addr;
  frame_t             ram_wr_data;
  logic [FRAME_W-1:0] ram_rd_addr;
  logic [$bits(frame_t)-1:0] ram_rd_raw;
  frame_t             rd_frame;

  logic [FRAME_W-1:0] step_src, step_next;
  logic               step_last;
  logic               in_range;

  assign rd_frame = frame_t'(ram_rd_raw);
  assign in_range = CMP_W'(frame_index) < CMP_W'(NUM_FRAMES);
  assign step_src = (state == ST_AIM) ? hand : cur;
  assign res      = res_r;

  cfr_step #(.NUM_FRAMES(NUM_FRAMES)) u_step (
    .operand (step_src),
    .next    (step_next),
    .last    (step_last)
  );

  cfr_ram #(.WIDTH($bits(frame_t)), .DEPTH(NUM_FRAMES)) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cur        <= '0;
      hand       <= '0;
      hand_valid <= 1'b0;
    end else begin
      state      <= state_next;
      cur        <= cur_next;
      hand       <= hand_next;
      hand_valid <= hand_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_next;
    act_r <= act_next;
    idx_r <= idx_next;
    wr_r  <= wr_next;
    sb_r  <= sb_next;
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    hand_next       = hand;
    hand_valid_next = hand_valid;
    res_next        = res_r;
    act_next        = act_r;
    idx_next        = idx_r;
    wr_next         = wr_r;
    sb_next         = sb_r;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = cur;
    ram_wr_data     = '0;
    ram_rd_addr     = step_next;
    req_ready       = 1'b0;
    res_valid       = 1'b0;

    case (state)
      ST_CLEAR: begin
        ram_wr_en = 1'b1;
        if (step_last) begin
          cur_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cur_next = step_next;
        end
      end

      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          act_next = action;
          idx_next = frame_index;
          wr_next  = is_write;
          sb_next  = page_swap_backed;
          res_next.granted_frame = frame_index;
          res_next.did_evict     = 1'b0;
          res_next.swap_out      = 1'b0;
          res_next.status        = 1'b0;
          case (action)
            ACT_ALLOC: begin
              ram_rd_addr = '0;
              cur_next    = '0;
              state_next  = ST_SCAN;
            end
            ACT_FREE, ACT_TOUCH: begin
              ram_rd_addr = FRAME_W'(frame_index);
              if (in_range) begin
                state_next = ST_LOOK;
              end else begin
                res_next.status = 1'b1;
                state_next      = ST_DONE;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_LOOK: begin
        ram_wr_addr = FRAME_W'(idx_r);
        if (!rd_frame.occupied) begin
          res_next.status = 1'b1;
        end else begin
          ram_wr_en = 1'b1;
          if (act_r == ACT_FREE) begin
            ram_wr_data = '0;
          end else begin
            ram_wr_data          = rd_frame;
            ram_wr_data.accessed = 1'b1;
            ram_wr_data.dirty    = rd_frame.dirty | wr_r;
          end
        end
        state_next = ST_DONE;
      end

      ST_SCAN: begin
        if (!rd_frame.occupied) begin
          ram_wr_en              = 1'b1;
          ram_wr_data            = place_page(sb_r);
          res_next.granted_frame = IDX_W'(cur);
          state_next             = ST_DONE;
        end else if (step_last) begin
          state_next = ST_AIM;
        end else begin
          cur_next = step_next;
        end
      end

      ST_AIM: begin
        // first sweep frame: after the hand, or frame 0 if never placed
        ram_rd_addr = hand_valid ? step_next : '0;
        cur_next    = ram_rd_addr;
        state_next  = ST_SWEEP;
      end

      ST_SWEEP: begin
        hand_next       = cur;
        hand_valid_next = 1'b1;
        ram_wr_en       = 1'b1;
        if (!rd_frame.accessed) begin
          ram_wr_data            = place_page(sb_r);
          res_next.granted_frame = IDX_W'(cur);
          res_next.did_evict     = 1'b1;
          res_next.swap_out      = rd_frame.dirty | rd_frame.swap_backed;
          state_next             = ST_DONE;
        end else begin
          ram_wr_data          = rd_frame;
          ram_wr_data.accessed = 1'b0;
          cur_next             = step_next;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_CLEAR;
        cur_next   = '0;
      end
    endcase
  end

endmodule

// ===== design/clock_frame_replacement_unit.sv =====
`timescale 1ns / 1ps

// Frame table with clock second-chance replacement.
// Request channel (req_valid/req_ready) carries action, frame_index, is_write
// and page_swap_backed; response channel (rsp_valid/rsp_ready) returns one
// transfer per request: granted_frame, did_evict, swap_out, status.
// Frame flags live in a single-port-write, registered-read RAM, walked one
// frame per cycle by a small sequencer around a shared cyclic cursor.
// One request is in work at a time; req_ready is low until its response
// moves to the output register, which then lets the next request in while
// it waits. Reset: after rst falls a clearing pass writes every frame with
// req_ready low. If the receiver stalls, the response holds in the output
// register and a finished second one waits in the sequencer.
module clock_frame_replacement_unit #(
  parameter int NUM_FRAMES = cfr_pkg::NUM_FRAMES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [cfr_pkg::ACT_W-1:0] action,
  input  logic [cfr_pkg::IDX_W-1:0] frame_index,
  input  logic                      is_write,
  input  logic                      page_swap_backed,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic [cfr_pkg::IDX_W-1:0] granted_frame,
  output logic                      did_evict,
  output logic                      swap_out,
  output logic                      status
);

  import cfr_pkg::*;

  logic res_valid;   // sequencer has a finished response
  logic res_ready;   // output register can take it
  rsp_t res;
  rsp_t out_r;
  logic out_valid;
  logic load;

  cfr_ctrl #(.NUM_FRAMES(NUM_FRAMES)) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .action           (action),
    .frame_index      (frame_index),
    .is_write         (is_write),
    .page_swap_backed (page_swap_backed),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  // output register: frees the sequencer while the receiver stalls
  assign res_ready = !out_valid || rsp_ready;
  assign load      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign rsp_valid     = out_valid;
  assign granted_frame = out_r.granted_frame;
  assign did_evict     = out_r.did_evict;
  assign swap_out      = out_r.swap_out;
  assign status        = out_r.status;

`ifndef SYNTHESIS
  // one request at a time: the sequencer drops ready on a transfer
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("req_ready high in the cycle after a request transfer");

  // a finished response is never pending while a new request is taken
  a_ready_vs_done: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && res_valid))
    else $error("request taken with a response still in the sequencer");

  // a swap write only comes with a successful eviction
  a_swap_needs_evict: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && swap_out) |-> (did_evict && !status))
    else $error("swap_out without an eviction");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// Clock second-chance frame table: random and directed requests on the
// request channel, every response transfer checked against a local model.
module tb;

  localparam int NUM_FRAMES   = cfr_pkg::NUM_FRAMES_DEF;
  localparam int ITEMS        = 1450;
  localparam int LIMIT_CYCLES = 1_000_000;
  // worst single request is a full-table sweep
  localparam int TAIL_CYCLES  = 3 * NUM_FRAMES;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 700;

  // action 3 is not decoded by the block: it must come back as a plain echo
  localparam logic [cfr_pkg::ACT_W-1:0] ACT_NONE = 2'd3;

  typedef struct {
    logic [cfr_pkg::ACT_W-1:0] act;
    logic [cfr_pkg::IDX_W-1:0] idx;
    logic                      wr;
    logic                      sb;
    int                        gap;    // idle cycles before it is offered
    bit                        drain;  // offered only once nothing is owed
  } frame_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      req_valid        = 1'b0;
  logic                      req_ready;
  logic [cfr_pkg::ACT_W-1:0] action           = '0;
  logic [cfr_pkg::IDX_W-1:0] frame_index      = '0;
  logic                      is_write         = 1'b0;
  logic                      page_swap_backed = 1'b0;
  logic                      rsp_valid;
  logic                      rsp_ready        = 1'b0;
  logic [cfr_pkg::IDX_W-1:0] granted_frame;
  logic                      did_evict;
  logic                      swap_out;
  logic                      status;

  clock_frame_replacement_unit #(
    .NUM_FRAMES(NUM_FRAMES)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .action           (action),
    .frame_index      (frame_index),
    .is_write         (is_write),
    .page_swap_backed (page_swap_backed),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp_ready),
    .granted_frame    (granted_frame),
    .did_evict        (did_evict),
    .swap_out         (swap_out),
    .status           (status)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow frame table: flags per frame, clock hand and its placed bit.
  // ---------------------------------------------------------------------
  cfr_pkg::frame_t frames [NUM_FRAMES];
  int              hand;
  bit              hand_placed;

  frame_req_t      pending_reqs[$];
  cfr_pkg::rsp_t   owed_rsps[$];
  frame_req_t      in_flight;
  int              gap_cnt;
  bit              drain_next;

  int fails;
  int rsp_seen;
  int cycles;
  int stall_cnt;
  int calm_cnt;
  bit long_hold_done;

  // Applies one request to the shadow table and returns the response it owes.
  function automatic cfr_pkg::rsp_t predict_frame_op(input frame_req_t r);
    cfr_pkg::rsp_t res;
    int            slot;
    int            n;
    bit            found;
    res.granted_frame = r.idx;
    res.did_evict     = 1'b0;
    res.swap_out      = 1'b0;
    res.status        = 1'b0;
    found             = 1'b0;
    slot              = 0;
    case (r.act)
      cfr_pkg::ACT_ALLOC: begin
        // lowest free frame wins
        for (n = 0; n < NUM_FRAMES; n++)
          if (!found && !frames[n].occupied) begin
            found = 1'b1;
            slot  = n;
          end
        if (!found) begin
          // full: sweep from the frame after the hand (frame 0 if never placed),
          // taking the accessed bit away from each frame passed over
          slot = hand_placed ? (hand + 1) % NUM_FRAMES : 0;
          for (n = 0; n < 2 * NUM_FRAMES + 1; n++) begin
            hand        = slot;
            hand_placed = 1'b1;
            if (!frames[slot].accessed)
              break;
            frames[slot].accessed = 1'b0;
            slot = (hand + 1) % NUM_FRAMES;
          end
          slot              = hand;
          res.did_evict     = 1'b1;
          res.swap_out      = frames[slot].dirty | frames[slot].swap_backed;
        end
        frames[slot].occupied    = 1'b1;
        frames[slot].accessed    = 1'b0;
        frames[slot].dirty       = 1'b0;
        frames[slot].swap_backed = r.sb;
        res.granted_frame        = slot[cfr_pkg::IDX_W-1:0];
      end
      cfr_pkg::ACT_FREE, cfr_pkg::ACT_TOUCH: begin
        if (r.idx >= NUM_FRAMES || !frames[r.idx].occupied)
          res.status = 1'b1;
        else if (r.act == cfr_pkg::ACT_FREE)
          frames[r.idx] = '0;
        else begin
          frames[r.idx].accessed = 1'b1;
          if (r.wr)
            frames[r.idx].dirty = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly back-to-back, some short gaps, the odd long one.
  function automatic int rand_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55)
      return 0;
    else if (roll < 85)
      return $urandom_range(3, 1);
    else if (roll < 97)
      return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic queue_req(input logic [cfr_pkg::ACT_W-1:0] act, input int idx,
                           input logic wr, input logic sb, input int gap);
    frame_req_t r;
    r.act      = act;
    r.idx      = idx[cfr_pkg::IDX_W-1:0];
    r.wr       = wr;
    r.sb       = sb;
    r.gap      = gap;
    r.drain    = drain_next;
    drain_next = 1'b0;
    pending_reqs.push_back(r);
  endtask

  task automatic check_field(input string fname, input int got, input int want);
    if (got != want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      fails++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------
  initial begin
    int  kind;
    int  len;
    int  n;
    int  roll;
    bit  calm;
    logic [cfr_pkg::ACT_W-1:0] op;

    for (n = 0; n < NUM_FRAMES; n++)
      frames[n] = '0;
    hand        = 0;
    hand_placed = 1'b0;
    fails       = 0;
    gap_cnt     = 0;
    drain_next  = 1'b0;

    // directed: empty table, unknown action, lowest-free reuse, flags ignored
    queue_req(cfr_pkg::ACT_TOUCH, 0, 1'b1, 1'b1, 0);   // touch of an unoccupied frame
    queue_req(cfr_pkg::ACT_FREE, 63, 1'b1, 1'b1, 0);   // free of an unoccupied frame
    queue_req(ACT_NONE, 63, 1'b1, 1'b1, 0);            // unknown action echoes
    queue_req(ACT_NONE, 0, 1'b0, 1'b0, 0);
    queue_req(cfr_pkg::ACT_ALLOC, 63, 1'b1, 1'b1, 0);  // index ignored -> frame 0
    queue_req(cfr_pkg::ACT_ALLOC, 0, 1'b0, 1'b0, 0);
    queue_req(cfr_pkg::ACT_ALLOC, 42, 1'b1, 1'b1, 0);
    queue_req(cfr_pkg::ACT_TOUCH, 1, 1'b1, 1'b0, 0);   // write touch marks dirty
    queue_req(cfr_pkg::ACT_TOUCH, 0, 1'b0, 1'b1, 0);
    queue_req(cfr_pkg::ACT_FREE, 1, 1'b0, 1'b0, 0);
    queue_req(cfr_pkg::ACT_TOUCH, 1, 1'b0, 1'b0, 0);   // freed frame is unoccupied again
    queue_req(cfr_pkg::ACT_ALLOC, 21, 1'b0, 1'b1, 0);  // hole at frame 1 is refilled
    queue_req(cfr_pkg::ACT_FREE, 0, 1'b1, 1'b1, 0);
    queue_req(cfr_pkg::ACT_FREE, 0, 1'b0, 1'b0, 0);    // double free
    queue_req(cfr_pkg::ACT_TOUCH, 63, 1'b1, 1'b0, 0);
    drain_next = 1'b1;
    queue_req(cfr_pkg::ACT_ALLOC, 0, 1'b1, 1'b0, 3);
    queue_req(cfr_pkg::ACT_TOUCH, 2, 1'b1, 1'b1, 0);

    // random: chunks of mixed traffic that keep the table near full
    while (pending_reqs.size() < ITEMS) begin
      kind = $urandom_range(99);
      calm = ($urandom_range(4) == 0);
      if ($urandom_range(19) == 0)
        drain_next = 1'b1;
      if (kind < 6) begin
        // every frame accessed: the next eviction laps the whole table
        for (n = 0; n < NUM_FRAMES; n++)
          queue_req(cfr_pkg::ACT_TOUCH, n, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    calm ? 0 : rand_gap());
        queue_req(cfr_pkg::ACT_ALLOC, $urandom_range(63), 1'($urandom_range(1)),
                  1'($urandom_range(1)), calm ? 0 : rand_gap());
      end else if (kind < 20) begin
        // punch holes, then refill them and spill over into an eviction
        len = $urandom_range(6, 1);
        for (n = 0; n < len; n++)
          queue_req(cfr_pkg::ACT_FREE, $urandom_range(63), 1'($urandom_range(1)),
                    1'($urandom_range(1)), calm ? 0 : rand_gap());
        for (n = 0; n <= len; n++)
          queue_req(cfr_pkg::ACT_ALLOC, $urandom_range(63), 1'($urandom_range(1)),
                    1'($urandom_range(1)), calm ? 0 : rand_gap());
      end else begin
        len = $urandom_range(40, 10);
        for (n = 0; n < len; n++) begin
          roll = $urandom_range(99);
          if (roll < 40)
            op = cfr_pkg::ACT_ALLOC;
          else if (roll < 78)
            op = cfr_pkg::ACT_TOUCH;
          else if (roll < 95)
            op = cfr_pkg::ACT_FREE;
          else
            op = ACT_NONE;
          queue_req(op, $urandom_range(63), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    calm ? 0 : rand_gap());
        end
      end
    end

    // sampled away from the active edge so the driver and monitor have settled
    while (pending_reqs.size() != 0 || req_valid || owed_rsps.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Reset once; the block then runs its clearing pass.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Driver: the request transfer happens on valid & ready; the model is
  // stepped right there, then the next item (if due) goes on the bus.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready)
        owed_rsps.push_back(predict_frame_op(in_flight));
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && !(pending_reqs[0].drain && owed_rsps.size() != 0)
            && gap_cnt >= pending_reqs[0].gap) begin
          in_flight         = pending_reqs.pop_front();
          gap_cnt           = 0;
          req_valid        <= 1'b1;
          action           <= in_flight.act;
          frame_index      <= in_flight.idx;
          is_write         <= in_flight.wr;
          page_swap_backed <= in_flight.sb;
        end else begin
          // a drain item holds its gap count until the pipe is empty
          if (pending_reqs.size() != 0 && !(pending_reqs[0].drain && owed_rsps.size() != 0))
            gap_cnt++;
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each response transfer, and throttles rsp_ready with
  // short stalls, the odd long one, calm stretches and one long hold-off
  // that should back the block up into req_ready.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    cfr_pkg::rsp_t want;
    int            roll;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (owed_rsps.size() == 0) begin
          $display("%0t: response with nothing outstanding, expected none, got frame %0d",
                   $time, granted_frame);
          fails++;
        end else begin
          want = owed_rsps.pop_front();
          check_field("granted_frame", int'(granted_frame), int'(want.granted_frame));
          check_field("did_evict", int'(did_evict), int'(want.did_evict));
          check_field("swap_out", int'(swap_out), int'(want.swap_out));
          check_field("status", int'(status), int'(want.status));
        end
        rsp_seen++;
      end
      if (!long_hold_done && rsp_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_cnt      = LONG_HOLD;
        calm_cnt       = 0;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        rsp_ready <= 1'b0;
      end else if (calm_cnt > 0) begin
        calm_cnt--;
        rsp_ready <= 1'b1;
      end else begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          calm_cnt   = $urandom_range(150, 40);
          rsp_ready <= 1'b1;
        end else if (roll < 25) begin
          stall_cnt  = (roll < 23) ? $urandom_range(3, 1) : $urandom_range(40, 10);
          rsp_ready <= 1'b0;
        end else begin
          rsp_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
